// File: hw/rtl/lfsq_pkg.sv
`default_nettype none

package lfsq_pkg;

	// grid geometry
	localparam int unsigned MAX_COLS = 1024;
	localparam int unsigned MAX_ROWS = 1024;
	localparam int unsigned COL_W    = $clog2(MAX_COLS);
	localparam int unsigned ROW_W    = $clog2(MAX_ROWS);

	// square side values and register fields
	localparam int unsigned VAL_W = 11;
	localparam logic [VAL_W-1:0] VAL_MAX = '1;

	// configuration port
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	// register index codes (paddr bit 2)
	localparam logic REG_ROW_LENGTH = 1'b0;
	localparam logic REG_ROW_COUNT  = 1'b1;

	// last index for a length register: zero acts as one, large values clamp
	function automatic logic [VAL_W-1:0] last_index(input logic [VAL_W-1:0] len,
			input logic [VAL_W-1:0] maxv);
		logic [VAL_W-1:0] eff;
		begin
			if (len == '0) begin
				eff = VAL_W'(1);
			end else if (len > maxv) begin
				eff = maxv;
			end else begin
				eff = len;
			end
			last_index = eff - VAL_W'(1);
		end
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lfsq_ram.sv
`default_nettype none

module lfsq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/largest_free_square_finder.sv
// pipeline: a cell reads the line buffer when it is accepted and is scored in the next cycle;
//   a grid's result goes from that scoring stage into the output register, or into the skid
//   register when the result buffer has an older result waiting
// throughput: one cell per cycle, set by the one-read one-write line buffer; results wait in
//   a two-entry buffer, and only a grid's last cell is held off while that buffer has no room
// reset: asynchronous, active low; registers go to 1024 cells by 1024 rows, position and best
//   are cleared, the line buffer is left unwritten
`default_nettype none

module largest_free_square_finder (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration port
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [lfsq_pkg::PADDR_W-1:0]      paddr,
	input  wire logic [lfsq_pkg::PDATA_W-1:0]      pwdata,
	output logic      [lfsq_pkg::PDATA_W-1:0]      prdata,
	output logic                                   pready,
	// cell input channel
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              cell_free,
	// result channel
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [lfsq_pkg::VAL_W-1:0]        square_size,
	output logic      [lfsq_pkg::ROW_W-1:0]        corner_row,
	output logic      [lfsq_pkg::COL_W-1:0]        corner_col
);

	localparam int unsigned VW = lfsq_pkg::VAL_W;
	localparam int unsigned CW = lfsq_pkg::COL_W;
	localparam int unsigned RW = lfsq_pkg::ROW_W;

	logic [VW-1:0] row_length_q;
	logic [VW-1:0] row_count_q;
	logic          cfg_wr;

	logic [CW-1:0] cols_m1;
	logic [RW-1:0] rows_m1;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          in_take;
	logic          cell_last;

	logic          valid_s1;
	logic          free_s1;
	logic          last_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	logic          fwd_s1;
	logic [VW-1:0] fwd_val_s1;

	logic [VW-1:0] left_q;
	logic [VW-1:0] diag_q;
	logic [VW-1:0] best_size_q;
	logic [RW-1:0] best_row_q;
	logic [CW-1:0] best_col_q;

	logic [VW-1:0] ram_rdata;
	logic [VW-1:0] up_val;
	logic [VW-1:0] min_val;
	logic [VW-1:0] cell_val;
	logic          new_best;

	logic          res_load;
	logic [VW-1:0] res_size;
	logic [RW-1:0] res_row;
	logic [CW-1:0] res_col;
	logic          out_free;
	logic          slot_ok;

	logic          out_valid_q;
	logic [VW-1:0] out_size_q;
	logic [RW-1:0] out_row_q;
	logic [CW-1:0] out_col_q;

	logic          skid_valid_q;
	logic [VW-1:0] skid_size_q;
	logic [RW-1:0] skid_row_q;
	logic [CW-1:0] skid_col_q;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= VW'(lfsq_pkg::MAX_COLS);
			row_count_q  <= VW'(lfsq_pkg::MAX_ROWS);
		end else if (cfg_wr) begin
			case (paddr[2])
				lfsq_pkg::REG_ROW_LENGTH: row_length_q <= pwdata[VW-1:0];
				lfsq_pkg::REG_ROW_COUNT:  row_count_q  <= pwdata[VW-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[2])
			lfsq_pkg::REG_ROW_LENGTH: prdata = lfsq_pkg::PDATA_W'(row_length_q);
			lfsq_pkg::REG_ROW_COUNT:  prdata = lfsq_pkg::PDATA_W'(row_count_q);
			default:                  prdata = '0;
		endcase
	end

	// effective grid bounds
	assign cols_m1 = CW'(lfsq_pkg::last_index(row_length_q, VW'(lfsq_pkg::MAX_COLS)));
	assign rows_m1 = RW'(lfsq_pkg::last_index(row_count_q, VW'(lfsq_pkg::MAX_ROWS)));

	// only a grid's last cell needs a free result slot by the time it is scored
	assign in_ready  = !cell_last || slot_ok;
	assign in_take   = in_valid && in_ready;
	assign cell_last = (row_q == rows_m1) && (col_q == cols_m1);

	// scan position of the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_take) begin
			if (cell_last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_q == cols_m1) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// line buffer: previous row's values
	lfsq_ram #(
		.WIDTH(VW),
		.DEPTH(lfsq_pkg::MAX_COLS)
	) u_line_buf (
		.clk  (clk),
		.we   (valid_s1),
		.waddr(col_s1),
		.wdata(cell_val),
		.re   (in_take),
		.raddr(col_q),
		.rdata(ram_rdata)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take;
		end
	end

	// stage 1 payload, plus bypass when the write of the scored cell hits the read address
	always_ff @(posedge clk) begin
		if (in_take) begin
			free_s1    <= cell_free;
			last_s1    <= cell_last;
			col_s1     <= col_q;
			row_s1     <= row_q;
			fwd_s1     <= valid_s1 && (col_s1 == col_q);
			fwd_val_s1 <= cell_val;
		end
	end

	// score the cell
	assign up_val = fwd_s1 ? fwd_val_s1 : ram_rdata;

	always_comb begin
		min_val = up_val;
		if (left_q < min_val) begin
			min_val = left_q;
		end
		if (diag_q < min_val) begin
			min_val = diag_q;
		end
		if (!free_s1) begin
			cell_val = '0;
		end else if (row_s1 == '0 || col_s1 == '0) begin
			cell_val = VW'(1);
		end else if (min_val == lfsq_pkg::VAL_MAX) begin
			cell_val = lfsq_pkg::VAL_MAX;
		end else begin
			cell_val = min_val + VW'(1);
		end
	end

	assign new_best = cell_val > best_size_q;

	// left and up-left neighbors for the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			diag_q <= '0;
		end else if (cfg_wr) begin
			left_q <= '0;
			diag_q <= '0;
		end else if (valid_s1) begin
			left_q <= cell_val;
			diag_q <= up_val;
		end
	end

	// best square so far, first one wins on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_size_q <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
		end else if (cfg_wr || (valid_s1 && last_s1)) begin
			best_size_q <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
		end else if (valid_s1 && new_best) begin
			best_size_q <= cell_val;
			best_row_q  <= row_s1;
			best_col_q  <= col_s1;
		end
	end

	// grid result of the cell being scored
	assign res_load = valid_s1 && last_s1;
	assign res_size = new_best ? cell_val : best_size_q;
	assign res_row  = new_best ? row_s1 : best_row_q;
	assign res_col  = new_best ? col_s1 : best_col_q;
	assign out_free = !out_valid_q || out_ready;

	// room for one more grid result by the time a last cell accepted now is scored
	always_comb begin
		if (skid_valid_q) begin
			slot_ok = out_ready && !res_load;
		end else begin
			slot_ok = out_free || !res_load;
		end
	end

	// two-entry result buffer: output register and a skid register behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || res_load;
			skid_valid_q <= skid_valid_q && res_load;
		end else if (res_load) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_size_q <= skid_size_q;
				out_row_q  <= skid_row_q;
				out_col_q  <= skid_col_q;
			end else if (res_load) begin
				out_size_q <= res_size;
				out_row_q  <= res_row;
				out_col_q  <= res_col;
			end
		end
		if (res_load && (skid_valid_q || !out_free)) begin
			skid_size_q <= res_size;
			skid_row_q  <= res_row;
			skid_col_q  <= res_col;
		end
	end

	assign out_valid   = out_valid_q;
	assign square_size = out_size_q;
	assign corner_row  = out_row_q;
	assign corner_col  = out_col_q;

	// a grid result never lands on a full buffer
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && skid_valid_q) |-> out_ready)
		else $error("result buffer overwritten");

	// the skid register only holds a result behind the output register
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register ahead of output register");

	// a result appears only right after a grid's last cell was scored
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && last_s1))
		else $error("result without a last cell");

	// scan position stays inside the configured grid
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= cols_m1) && (row_q <= rows_m1))
		else $error("scan position out of range");

	// a same-address read behind a write is served by the bypass
	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && valid_s1 && (col_s1 == col_q)) |=> fwd_s1)
		else $error("line buffer bypass missed");

endmodule

`default_nettype wire
